FILE: rtl/ipv4rhc_pkg.sv
// Package with shared constants, codes and types of the IPv4 receive header check.
package ipv4rhc_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam int ADDR_WIDTH = 3;
   localparam int DATA_WIDTH = 32;

   localparam logic [ADDR_WIDTH-1:0] REG_LOCAL_ADDRESS = 3'd0;

   localparam logic [5:0]  MIN_HEADER     = 6'd20;
   localparam logic [15:0] MIN_HEADER_LEN = 16'd20;
   localparam logic [3:0]  IP_VERSION     = 4'd4;
   localparam logic [7:0]  PROTO_ICMP     = 8'd1;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [15:0] MORE_FRAGMENTS = 16'h2000;
   localparam logic [15:0] OFFSET_MASK    = 16'h1FFF;
   localparam logic [16:0] SUM_GOOD       = 17'h0FFFF;
   localparam logic [31:0] BROADCAST      = 32'hFFFF_FFFF;

   typedef enum logic [3:0] {
      VERDICT_ICMP     = 4'd0,
      VERDICT_UDP      = 4'd1,
      VERDICT_SHORT    = 4'd2,
      VERDICT_VERSION  = 4'd3,
      VERDICT_HDRLEN   = 4'd4,
      VERDICT_TOTLEN   = 4'd5,
      VERDICT_FRAGMENT = 4'd6,
      VERDICT_CHECKSUM = 4'd7,
      VERDICT_NOTOURS  = 4'd8,
      VERDICT_PROTO    = 4'd9
   } verdict_type;

   typedef struct packed {
      verdict_type verdict;
      logic [31:0] source_address;
      logic [5:0]  payload_offset;
      logic [15:0] payload_length;
      logic [31:0] drop_total;
   } result_type;

endpackage

FILE: rtl/ipv4rhc_req_if.sv
// Input channel interface carrying one packet byte per item.
interface ipv4rhc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: rtl/ipv4rhc_rsp_if.sv
// Result channel interface carrying one packet verdict per item.
interface ipv4rhc_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  verdict;
   logic [31:0] source_address;
   logic [5:0]  payload_offset;
   logic [15:0] payload_length;
   logic [31:0] drop_total;

   modport source (output valid, output verdict, output source_address,
                   output payload_offset, output payload_length, output drop_total,
                   input ready);
   modport sink (input valid, input verdict, input source_address,
                 input payload_offset, input payload_length, input drop_total,
                 output ready);
endinterface

FILE: rtl/ipv4rhc_csr.sv
// APB register block holding the local IPv4 address.
module ipv4rhc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ipv4rhc_pkg::ADDR_WIDTH-1:0] paddr,
   input  logic [ipv4rhc_pkg::DATA_WIDTH-1:0] pwdata,
   output logic [ipv4rhc_pkg::DATA_WIDTH-1:0] prdata,
   output logic                               pready,
   output logic [31:0]                        local_address
);

   logic [31:0] local_ff;
   logic [31:0] local_in;
   logic        hit;

   assign hit = (paddr == ipv4rhc_pkg::REG_LOCAL_ADDRESS);

   always_comb begin
      local_in = local_ff;
      if (psel && penable && pwrite && hit) begin
         local_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ff <= '0;
      end else begin
         local_ff <= local_in;
      end
   end

   assign prdata        = hit ? local_ff : '0;
   assign pready        = 1'b1;
   assign local_address = local_ff;

endmodule

FILE: rtl/ipv4rhc_core.sv
// Byte parser, header checker and verdict register of the IPv4 receive path.
module ipv4rhc_core #(
   parameter int COUNT_WIDTH = ipv4rhc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] local_address,
   ipv4rhc_req_if.sink   req_ch,
   ipv4rhc_rsp_if.source rsp_ch
);

   localparam logic [COUNT_WIDTH-1:0] POS_MAX = {COUNT_WIDTH{1'b1}};

   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic                   in_last_ff;
   logic                   out_valid_ff;
   ipv4rhc_pkg::result_type out_ff;
   ipv4rhc_pkg::result_type out_in;

   logic [COUNT_WIDTH-1:0] pos_ff, pos_in;
   logic [7:0]             vl_ff, vl_in;
   logic [15:0]            tot_ff, tot_in;
   logic [15:0]            frag_ff, frag_in;
   logic [7:0]             proto_ff, proto_in;
   logic [31:0]            src_ff, src_in;
   logic [31:0]            dst_ff, dst_in;
   logic [16:0]            sum_ff, sum_in;
   logic [31:0]            drop_ff, drop_in;

   logic                   out_free;
   logic                   advance;
   logic [5:0]             hlen;
   logic [15:0]            addend;
   logic [17:0]            sum_raw;
   logic [15:0]            len16;
   ipv4rhc_pkg::verdict_type verdict;

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && (!in_last_ff || out_free);
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      vl_in    = vl_ff;
      tot_in   = tot_ff;
      frag_in  = frag_ff;
      proto_in = proto_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      if (pos_ff == COUNT_WIDTH'(0)) begin
         vl_in = in_byte_ff;
      end else if (pos_ff == COUNT_WIDTH'(2) || pos_ff == COUNT_WIDTH'(3)) begin
         tot_in = {tot_ff[7:0], in_byte_ff};
      end else if (pos_ff == COUNT_WIDTH'(6) || pos_ff == COUNT_WIDTH'(7)) begin
         frag_in = {frag_ff[7:0], in_byte_ff};
      end else if (pos_ff == COUNT_WIDTH'(9)) begin
         proto_in = in_byte_ff;
      end else if (pos_ff >= COUNT_WIDTH'(12) && pos_ff <= COUNT_WIDTH'(15)) begin
         src_in = {src_ff[23:0], in_byte_ff};
      end else if (pos_ff >= COUNT_WIDTH'(16) && pos_ff <= COUNT_WIDTH'(19)) begin
         dst_in = {dst_ff[23:0], in_byte_ff};
      end
   end

   assign hlen    = {vl_in[3:0], 2'b00};
   assign addend  = pos_ff[0] ? {8'h00, in_byte_ff} : {in_byte_ff, 8'h00};
   assign sum_raw = {1'b0, sum_ff} + {2'b00, addend};

   always_comb begin
      sum_in = sum_ff;
      if (pos_ff < COUNT_WIDTH'(hlen)) begin
         if (sum_raw > 18'h0FFFF) begin
            sum_in = {1'b0, sum_raw[15:0]} + 17'd1;
         end else begin
            sum_in = sum_raw[16:0];
         end
      end
   end

   assign pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + COUNT_WIDTH'(1);
   assign len16  = 16'(pos_in);

   always_comb begin
      priority if (len16 < ipv4rhc_pkg::MIN_HEADER_LEN) begin
         verdict = ipv4rhc_pkg::VERDICT_SHORT;
      end else if (vl_in[7:4] != ipv4rhc_pkg::IP_VERSION) begin
         verdict = ipv4rhc_pkg::VERDICT_VERSION;
      end else if (hlen < ipv4rhc_pkg::MIN_HEADER || 16'(hlen) > len16) begin
         verdict = ipv4rhc_pkg::VERDICT_HDRLEN;
      end else if (tot_in < 16'(hlen) || tot_in > len16) begin
         verdict = ipv4rhc_pkg::VERDICT_TOTLEN;
      end else if ((frag_in & ipv4rhc_pkg::MORE_FRAGMENTS) != '0
                   || (frag_in & ipv4rhc_pkg::OFFSET_MASK) != '0) begin
         verdict = ipv4rhc_pkg::VERDICT_FRAGMENT;
      end else if (sum_in != ipv4rhc_pkg::SUM_GOOD) begin
         verdict = ipv4rhc_pkg::VERDICT_CHECKSUM;
      end else if (dst_in != local_address && dst_in != ipv4rhc_pkg::BROADCAST) begin
         verdict = ipv4rhc_pkg::VERDICT_NOTOURS;
      end else if (proto_in == ipv4rhc_pkg::PROTO_ICMP) begin
         verdict = ipv4rhc_pkg::VERDICT_ICMP;
      end else if (proto_in == ipv4rhc_pkg::PROTO_UDP) begin
         verdict = ipv4rhc_pkg::VERDICT_UDP;
      end else begin
         verdict = ipv4rhc_pkg::VERDICT_PROTO;
      end
   end

   always_comb begin
      drop_in                = drop_ff;
      out_in.verdict         = verdict;
      out_in.source_address  = src_in;
      out_in.payload_offset  = hlen;
      out_in.payload_length  = '0;
      if (verdict == ipv4rhc_pkg::VERDICT_ICMP || verdict == ipv4rhc_pkg::VERDICT_UDP) begin
         out_in.payload_length = tot_in - 16'(hlen);
      end else begin
         drop_in = drop_ff + 32'd1;
      end
      out_in.drop_total = drop_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
         vl_ff        <= '0;
         tot_ff       <= '0;
         frag_ff      <= '0;
         proto_ff     <= '0;
         src_ff       <= '0;
         dst_ff       <= '0;
         sum_ff       <= '0;
         drop_ff      <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            in_valid_ff <= 1'b1;
            in_byte_ff  <= req_ch.data_byte;
            in_last_ff  <= req_ch.last_byte;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance && in_last_ff) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (advance) begin
            if (in_last_ff) begin
               out_ff       <= out_in;
               drop_ff      <= drop_in;
               pos_ff       <= '0;
               vl_ff        <= '0;
               tot_ff       <= '0;
               frag_ff      <= '0;
               proto_ff     <= '0;
               src_ff       <= '0;
               dst_ff       <= '0;
               sum_ff       <= '0;
            end else begin
               pos_ff   <= pos_in;
               vl_ff    <= vl_in;
               tot_ff   <= tot_in;
               frag_ff  <= frag_in;
               proto_ff <= proto_in;
               src_ff   <= src_in;
               dst_ff   <= dst_in;
               sum_ff   <= sum_in;
            end
         end
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.verdict        = out_ff.verdict;
   assign rsp_ch.source_address = out_ff.source_address;
   assign rsp_ch.payload_offset = out_ff.payload_offset;
   assign rsp_ch.payload_length = out_ff.payload_length;
   assign rsp_ch.drop_total     = out_ff.drop_total;

endmodule

FILE: rtl/ipv4_receive_header_check_unit.sv
// Top level of the IPv4 receive header check unit.
//
//  Channel   Direction  Handshake      Contents
//  req_ch    in         valid/ready    data_byte, last_byte
//  rsp_ch    out        valid/ready    verdict, source_address, payload_offset,
//                                      payload_length, drop_total
//  APB       in         psel/penable   local_address at byte address 0
//
// The unit takes one byte per cycle while no last byte waits on the result channel; each byte
// passes an input register and one stage of header logic before the verdict register.
// Bytes that are not last never wait on the result channel; a last byte waits
// in the input register while an earlier verdict is not yet taken.
// Reset clears the handshakes, the captured header fields and the drop counter.
module ipv4_receive_header_check_unit #(
   parameter int COUNT_WIDTH = ipv4rhc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   ipv4rhc_req_if.sink                        req_ch,
   ipv4rhc_rsp_if.source                      rsp_ch,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ipv4rhc_pkg::ADDR_WIDTH-1:0] paddr,
   input  logic [ipv4rhc_pkg::DATA_WIDTH-1:0] pwdata,
   output logic [ipv4rhc_pkg::DATA_WIDTH-1:0] prdata,
   output logic                               pready
);

   logic [31:0] local_address;

   ipv4rhc_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .local_address (local_address)
   );

   ipv4rhc_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .local_address (local_address),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch)
   );

endmodule

FILE: rtl/ipv4rhc_checker.sv
// Port checker for the IPv4 receive header check unit and its bind.
module ipv4rhc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  verdict,
   input logic [5:0]  payload_offset,
   input logic [15:0] payload_length,
   input logic [31:0] drop_total
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid right after reset.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(verdict) && $stable(drop_total))
      else $error("Stalled result changed.");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> verdict <= ipv4rhc_pkg::VERDICT_PROTO)
      else $error("Verdict code out of range.");

   a_deliver: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (verdict == ipv4rhc_pkg::VERDICT_ICMP || verdict == ipv4rhc_pkg::VERDICT_UDP)
      |-> payload_offset >= ipv4rhc_pkg::MIN_HEADER && payload_offset[1:0] == 2'b00)
      else $error("Delivered packet with an invalid header length.");

   a_drop_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && verdict >= ipv4rhc_pkg::VERDICT_SHORT |-> payload_length == 16'd0)
      else $error("Dropped packet reports a payload length.");

endmodule

bind ipv4_receive_header_check_unit ipv4rhc_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .verdict        (rsp_ch.verdict),
   .payload_offset (rsp_ch.payload_offset),
   .payload_length (rsp_ch.payload_length),
   .drop_total     (rsp_ch.drop_total)
);
